// ----- design/mscc_pkg.sv -----
// ----------------------------------------------------------------------------
// mscc_pkg
// Shared types, constants and tables for the marching squares contour unit.
// ----------------------------------------------------------------------------
package mscc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COORD_W  = 16;
    localparam int NUM_FACE = 3;

    localparam logic [2:0] NO_EDGE = 3'd4;

    typedef enum logic [1:0]
    {
        FACE_XY = 2'd0,
        FACE_YZ = 2'd1,
        FACE_XZ = 2'd2
    } face_t;

    typedef struct packed
    {
        logic [2:0] e0;
        logic [2:0] e1;
    } edge_pair_t;

    // pt[0] start point, pt[1] end point; inner index x, y, z
    typedef struct packed
    {
        logic [1:0][2:0][COORD_W-1:0] pt;
    } seg_t;

    typedef struct packed
    {
        logic hit;
        seg_t seg;
    } lane_res_t;

    // crossed edge pair for a corner mask
    function automatic edge_pair_t edge_pair(input logic [3:0] mask);
        edge_pair_t p;
        case (mask)
            4'd1:    p = '{e0: 3'd0, e1: 3'd3};
            4'd2:    p = '{e0: 3'd0, e1: 3'd1};
            4'd3:    p = '{e0: 3'd1, e1: 3'd3};
            4'd4:    p = '{e0: 3'd1, e1: 3'd2};
            4'd6:    p = '{e0: 3'd0, e1: 3'd2};
            4'd7:    p = '{e0: 3'd2, e1: 3'd3};
            4'd8:    p = '{e0: 3'd2, e1: 3'd3};
            4'd9:    p = '{e0: 3'd0, e1: 3'd2};
            4'd11:   p = '{e0: 3'd1, e1: 3'd2};
            4'd12:   p = '{e0: 3'd1, e1: 3'd3};
            4'd13:   p = '{e0: 3'd0, e1: 3'd1};
            4'd14:   p = '{e0: 3'd0, e1: 3'd3};
            default: p = '{e0: NO_EDGE, e1: NO_EDGE};
        endcase
        return p;
    endfunction

    // corner offset of a face corner, bit 0 x, bit 1 y, bit 2 z
    function automatic logic [2:0] corner_off(input face_t f, input logic [1:0] c);
        logic [2:0] o;
        o = 3'b000;
        case (f)
            FACE_XY:
            begin
                case (c)
                    2'd1:    o = 3'b001;
                    2'd2:    o = 3'b011;
                    2'd3:    o = 3'b010;
                    default: o = 3'b000;
                endcase
            end
            FACE_YZ:
            begin
                case (c)
                    2'd1:    o = 3'b010;
                    2'd2:    o = 3'b110;
                    2'd3:    o = 3'b100;
                    default: o = 3'b000;
                endcase
            end
            FACE_XZ:
            begin
                case (c)
                    2'd1:    o = 3'b100;
                    2'd2:    o = 3'b101;
                    2'd3:    o = 3'b001;
                    default: o = 3'b000;
                endcase
            end
            default: o = 3'b000;
        endcase
        return o;
    endfunction

endpackage

// ----- design/mscc_div.sv -----
// ----------------------------------------------------------------------------
// mscc_div
// Pipelined restoring divider, one quotient bit per stage, for the edge
// fraction (num << FRAC_BITS) / den. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module mscc_div
    import mscc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [SAMPLE_W-1:0]           num,
    input  logic [SAMPLE_W-1:0]           den,
    output logic [FRAC_BITS+SAMPLE_W-1:0] quo
);

    localparam int QW = FRAC_BITS + SAMPLE_W;

    logic [SAMPLE_W-1:0] rem_in   [QW];
    logic [SAMPLE_W-1:0] den_in   [QW];
    logic [QW-1:0]       dvd_in   [QW];
    logic [QW-1:0]       quo_in   [QW];
    logic [SAMPLE_W-1:0] rem_next [QW];
    logic [QW-1:0]       dvd_next [QW];
    logic [QW-1:0]       quo_next [QW];
    logic [SAMPLE_W-1:0] rem_reg  [QW];
    logic [SAMPLE_W-1:0] den_reg  [QW];
    logic [QW-1:0]       dvd_reg  [QW];
    logic [QW-1:0]       quo_reg  [QW];

    assign rem_in[0] = '0;
    assign den_in[0] = den;
    assign dvd_in[0] = {num, {FRAC_BITS{1'b0}}};
    assign quo_in[0] = '0;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [SAMPLE_W:0] trial;
        logic [SAMPLE_W:0] diff;
        logic              ge;

        if (s > 0)
        begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign den_in[s] = den_reg[s-1];
            assign dvd_in[s] = dvd_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
        end

        assign trial       = {rem_in[s], dvd_in[s][QW-1]};
        assign ge          = trial >= {1'b0, den_in[s]};
        assign diff        = trial - {1'b0, den_in[s]};
        assign rem_next[s] = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        assign dvd_next[s] = {dvd_in[s][QW-2:0], 1'b0};
        assign quo_next[s] = {quo_in[s][QW-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_in[s];
                dvd_reg[s] <= dvd_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo = (den_reg[QW-1] == '0) ? '0 : quo_reg[QW-1];

endmodule

// ----- design/mscc_lane.sv -----
// ----------------------------------------------------------------------------
// mscc_lane
// One face lane: corner mask, edge pair lookup, a divider per crossed edge
// and the saturated Q coordinates of the segment end points.
// ----------------------------------------------------------------------------
module mscc_lane
    import mscc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          en,
    input  face_t                         face,
    input  logic [SAMPLE_W-1:0]           iso,
    input  logic                          in_grid,
    input  logic [2:0][SAMPLE_W-1:0]      pos,
    input  logic [3:0][SAMPLE_W-1:0]      val,
    output lane_res_t                     res
);

    localparam int QW = FRAC_BITS + SAMPLE_W;
    localparam int CW = (FRAC_BITS + 11 > 17) ? FRAC_BITS + 11 : 17;

    typedef struct packed
    {
        logic [2:0][SAMPLE_W-1:0] pos;
        logic [1:0][1:0]          edge_sel;
        logic                     hit;
    } side_t;

    logic [3:0]          mask;
    edge_pair_t          pair;
    side_t               side_in;
    side_t               side_reg [QW];
    side_t               tail;
    logic [SAMPLE_W-1:0] num [2];
    logic [SAMPLE_W-1:0] den [2];
    logic [QW-1:0]       quo [2];
    logic [2:0]          off_a [2];
    logic [2:0]          off_b [2];
    logic [SAMPLE_W:0]   p9    [2][3];
    logic [CW-1:0]       base  [2][3];
    logic [CW-1:0]       sum   [2][3];
    lane_res_t           res_next;
    lane_res_t           res_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mask[i] = val[i] > iso;
        end
        pair                = edge_pair(mask);
        side_in.pos         = pos;
        side_in.edge_sel[0] = pair.e0[1:0];
        side_in.edge_sel[1] = pair.e1[1:0];
        side_in.hit         = (pair.e0 != NO_EDGE) && in_grid;
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_end
        logic [1:0]          ca;
        logic [1:0]          cb;
        logic [SAMPLE_W-1:0] d0;
        logic [SAMPLE_W-1:0] d1;

        assign ca     = side_in.edge_sel[k];
        assign cb     = ca + 2'd1;
        assign d0     = val[ca];
        assign d1     = val[cb];
        assign num[k] = (iso >= d0) ? iso - d0 : d0 - iso;
        assign den[k] = (d1 >= d0) ? d1 - d0 : d0 - d1;

        mscc_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num[k]),
            .den (den[k]),
            .quo (quo[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign tail = side_reg[QW-1];

    always_comb
    begin
        res_next.hit = tail.hit;
        for (int k = 0; k < 2; k++)
        begin
            off_a[k] = corner_off(face, tail.edge_sel[k]);
            off_b[k] = corner_off(face, tail.edge_sel[k] + 2'd1);
            for (int ax = 0; ax < 3; ax++)
            begin
                p9[k][ax]   = {1'b0, tail.pos[ax]} + {{SAMPLE_W{1'b0}}, off_a[k][ax]};
                base[k][ax] = CW'(p9[k][ax]) << FRAC_BITS;
                if (off_b[k][ax] && !off_a[k][ax])
                begin
                    sum[k][ax] = base[k][ax] + CW'(quo[k]);
                end
                else if (!off_b[k][ax] && off_a[k][ax])
                begin
                    sum[k][ax] = base[k][ax] - CW'(quo[k]);
                end
                else
                begin
                    sum[k][ax] = base[k][ax];
                end
                // below zero or above range both saturate high
                if (sum[k][ax][CW-1:COORD_W] != '0)
                begin
                    res_next.seg.pt[k][ax] = {COORD_W{1'b1}};
                end
                else
                begin
                    res_next.seg.pt[k][ax] = sum[k][ax][COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- design/mscc_merge.sv -----
// ----------------------------------------------------------------------------
// mscc_merge
// Gathers the three lane results of a cell and sends the crossed faces one
// beat at a time through the output register, marking the final one.
// ----------------------------------------------------------------------------
module mscc_merge
    import mscc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tail_valid,
    input  lane_res_t [NUM_FACE-1:0] res,
    output logic                     take,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_face,
    output seg_t                     out_seg,
    output logic                     out_last
);

    logic [NUM_FACE-1:0] pend_reg;
    logic [NUM_FACE-1:0] pend_next;
    logic [NUM_FACE-1:0] pend_after;
    logic [NUM_FACE-1:0] sel;
    logic [1:0]          idx;
    logic                out_free;
    logic                load;
    logic                capture;
    seg_t                seg_reg [NUM_FACE];
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          out_face_reg;
    seg_t                out_seg_reg;
    logic                out_last_reg;

    assign out_free   = !out_valid_reg || out_ready;
    assign load       = out_free && (pend_reg != '0);
    assign sel        = pend_reg & (~pend_reg + NUM_FACE'(1));
    assign pend_after = load ? (pend_reg & ~sel) : pend_reg;
    assign take       = (pend_after == '0);
    assign capture    = tail_valid && take;

    always_comb
    begin
        if (sel[0])
        begin
            idx = FACE_XY;
        end
        else if (sel[1])
        begin
            idx = FACE_YZ;
        end
        else
        begin
            idx = FACE_XZ;
        end
    end

    always_comb
    begin
        pend_next = pend_after;
        if (capture)
        begin
            for (int f = 0; f < NUM_FACE; f++)
            begin
                pend_next[f] = res[f].hit;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int f = 0; f < NUM_FACE; f++)
            begin
                seg_reg[f] <= res[f].seg;
            end
        end
        if (load)
        begin
            out_face_reg <= idx;
            out_seg_reg  <= seg_reg[idx];
            out_last_reg <= ((pend_reg & ~sel) == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_face  = out_face_reg;
    assign out_seg   = out_seg_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- design/marching_squares_cell_contour_unit.sv -----
// throughput: one cell per cycle while cells cross at most one face and out_ready is high;
// a cell crossing more faces stalls the cells behind it until the single result channel
// behind the merge stage has taken each of its segments
// reset: clears the pipeline valid bits, pending segments, output valid and the stored iso level to 0
// ----------------------------------------------------------------------------
// marching_squares_cell_contour_unit
// Three face lanes find the contour segment of the xy, yz and xz faces of
// a cell in parallel; a merge stage sends the segments out in face order.
// ----------------------------------------------------------------------------
module marching_squares_cell_contour_unit
    import mscc_pkg::*;
#(
    parameter int GRID_SIZE = 256,
    parameter int FRAC_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SAMPLE_W-1:0] iso_level,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] cell_x,
    input  logic [SAMPLE_W-1:0] cell_y,
    input  logic [SAMPLE_W-1:0] cell_z,
    input  logic [SAMPLE_W-1:0] sample_000,
    input  logic [SAMPLE_W-1:0] sample_100,
    input  logic [SAMPLE_W-1:0] sample_110,
    input  logic [SAMPLE_W-1:0] sample_010,
    input  logic [SAMPLE_W-1:0] sample_011,
    input  logic [SAMPLE_W-1:0] sample_001,
    input  logic [SAMPLE_W-1:0] sample_101,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          face,
    output logic [COORD_W-1:0]  start_x,
    output logic [COORD_W-1:0]  start_y,
    output logic [COORD_W-1:0]  start_z,
    output logic [COORD_W-1:0]  end_x,
    output logic [COORD_W-1:0]  end_y,
    output logic [COORD_W-1:0]  end_z,
    output logic                last
);

    localparam int QW    = FRAC_BITS + SAMPLE_W;
    localparam int DEPTH = QW + 2;
    localparam int LIM   = GRID_SIZE - 1;

    logic [SAMPLE_W-1:0]      iso_reg;
    logic [DEPTH-1:0]         vld_reg;
    logic [2:0][SAMPLE_W-1:0] pos_reg;
    logic [6:0][SAMPLE_W-1:0] smp_reg;
    logic                     en;
    logic                     take;
    logic                     in_grid;
    lane_res_t [NUM_FACE-1:0] res;
    seg_t                     out_seg;

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[DEPTH-1] || take;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                iso_reg <= iso_level;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= {cell_z, cell_y, cell_x};
            smp_reg <= {sample_101, sample_001, sample_011, sample_010,
                        sample_110, sample_100, sample_000};
        end
    end

    // cells with any coordinate at or above GRID_SIZE - 1 give no segments
    assign in_grid = (int'(pos_reg[0]) < LIM) && (int'(pos_reg[1]) < LIM)
                  && (int'(pos_reg[2]) < LIM);

    mscc_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_xy (
        .clk     (clk),
        .en      (en),
        .face    (FACE_XY),
        .iso     (iso_reg),
        .in_grid (in_grid),
        .pos     (pos_reg),
        .val     ({smp_reg[3], smp_reg[2], smp_reg[1], smp_reg[0]}),
        .res     (res[FACE_XY])
    );

    mscc_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_yz (
        .clk     (clk),
        .en      (en),
        .face    (FACE_YZ),
        .iso     (iso_reg),
        .in_grid (in_grid),
        .pos     (pos_reg),
        .val     ({smp_reg[5], smp_reg[4], smp_reg[3], smp_reg[0]}),
        .res     (res[FACE_YZ])
    );

    mscc_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_xz (
        .clk     (clk),
        .en      (en),
        .face    (FACE_XZ),
        .iso     (iso_reg),
        .in_grid (in_grid),
        .pos     (pos_reg),
        .val     ({smp_reg[1], smp_reg[6], smp_reg[5], smp_reg[0]}),
        .res     (res[FACE_XZ])
    );

    mscc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (vld_reg[DEPTH-1]),
        .res        (res),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_face   (face),
        .out_seg    (out_seg),
        .out_last   (last)
    );

    assign start_x = out_seg.pt[0][0];
    assign start_y = out_seg.pt[0][1];
    assign start_z = out_seg.pt[0][2];
    assign end_x   = out_seg.pt[1][0];
    assign end_y   = out_seg.pt[1][1];
    assign end_z   = out_seg.pt[1][2];

endmodule
